FILE: hw/rtl/deq_pkg.sv
// Package: command, position and status codes and default sizes for the deque.
`default_nettype none
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef enum logic [POS_W-1:0] {
        POS_HEAD     = 3'd0,
        POS_TAIL     = 3'd1,
        POS_CURRENT  = 3'd2,
        POS_NEXT     = 3'd3,
        POS_PREVIOUS = 3'd4
    } t_pos;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_FULL        = 2'd3
    } t_status;

endpackage
`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
// Double-ended queue of data words kept in a ring memory with head and tail pointers.
// The result strobe o_done is registered at the accepting edge.
// Throughput: one request per cycle while busy is low; pointer update, memory write and
// the synchronous memory read all happen at the accepting edge.
// busy is high only during reset and in the cycle after it; the receiver cannot stall.
// Reset (synchronous, active low) empties the queue; memory contents stay undefined.
`default_nettype none
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [POS_W-1:0]      i_position,
    input  wire logic [DATA_WIDTH-1:0] i_data_in,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [DATA_WIDTH-1:0]      o_data_out,
    output logic [CNT_W-1:0]           o_entry_count
);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    // Ring memory: written and read at the accepting edge, read data registered.
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Pointers: head indexes the head word, tail indexes one past the tail word.
    logic [IDX_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;

    // Result registers.
    logic                  r_busy;
    logic                  r_done;
    t_status               r_status, n_status;
    logic                  r_take, n_take;
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                  accept;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      base_head;
    logic [IDX_W-1:0]      base_tail;
    logic                  is_empty;
    logic                  is_full;
    logic                  pos_unsup;
    logic                  pos_bad;

    assign accept    = start && !busy;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= FULL_CNT);

    // An insert into an empty queue restarts both pointers at zero.
    assign base_head = is_empty ? '0 : r_head;
    assign base_tail = is_empty ? '0 : r_tail;

    assign pos_unsup = (t_pos'(i_position) == POS_CURRENT) ||
                       (t_pos'(i_position) == POS_NEXT) ||
                       (t_pos'(i_position) == POS_PREVIOUS);
    assign pos_bad   = (i_position > POS_PREVIOUS);

    // Decode the request: new pointers, memory access and status.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_OK;
        n_take   = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_tail;
        rd_addr  = r_head;
        unique case (t_cmd'(i_command))
            CMD_FLUSH: begin
                // Drop every word and return both pointers home.
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            CMD_INSERT: begin
                if (pos_unsup) begin
                    n_status = ST_UNSUPPORTED;
                end else if (pos_bad) begin
                    n_status = ST_INVALID;
                end else if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_tail  = base_tail;
                    n_head  = base_head;
                    if (t_pos'(i_position) == POS_HEAD) begin
                        // Step head back, then write the word there.
                        n_head  = (base_head == '0) ? LAST_IDX : base_head - 1'b1;
                        wr_addr = n_head;
                    end else begin
                        // Write at tail, then advance it.
                        wr_addr = base_tail;
                        n_tail  = (base_tail == LAST_IDX) ? '0 : base_tail + 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (pos_unsup) begin
                    n_status = ST_UNSUPPORTED;
                end else if (pos_bad || is_empty) begin
                    n_status = ST_INVALID;
                end else begin
                    n_take  = 1'b1;
                    n_count = r_count - 1'b1;
                    if (t_pos'(i_position) == POS_HEAD) begin
                        rd_addr = r_head;
                        n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    end else begin
                        n_tail  = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
                        rd_addr = n_tail;
                    end
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // Memory port: a remove and an insert never hit the same edge, and a word
    // written at one edge is visible to a read at the next.
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= i_data_in;
        end
        if (accept && n_take) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_busy <= 1'b0;
            r_done <= accept;
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // Result fields, held from the accepting edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take <= 1'b0;
        end else if (accept) begin
            r_take <= n_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_data_out    = r_take ? r_rd_data : '0;
    assign o_entry_count = r_count;

    // Checks.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted word gave no result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == FULL_CNT))
        else $error("full status while not full");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_FLUSH) |=> (o_entry_count == '0 && !r_take))
        else $error("flush left entries");

endmodule
`default_nettype wire
